FILE: rtl/sts_pkg.sv
package sts_pkg;

    // Kind of an input transaction, carried in tuser.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXACT = 2'd1,
        OP_LOWER = 2'd2,
        OP_UPPER = 2'd3
    } t_op;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_LENGTH   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPARE_SIGNED = 1'b1;

    localparam int LEN_W       = 11;
    localparam int IDX_W       = 10;
    localparam int IN_KEY_W    = 32;
    localparam int POS_W       = 11;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

endpackage

FILE: rtl/sts_key_ram.sv
module sts_key_ram #(
    parameter int DEPTH     = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [KEY_WIDTH-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [KEY_WIDTH-1:0]       o_rdata
);

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sorted_table_search.sv
// Binary search over a key table held in one synchronous RAM.
// Input stream: tuser carries the operation (write, exact find, lower bound,
// upper bound); tdata carries the entry index and the key. A write stores the
// key and returns nothing. A query searches the first
// table_length entries (clamped to DEPTH) and returns one transaction on the
// output stream: tdata holds the position, tuser the found flag.
// A query makes P probes, P at most ceil(log2(table_length + 1)) (11 at
// 1024 entries). Its result is registered in ST_FIN once the output register
// is free, and only then does the block go idle and take the next item, so
// a query holds the input until its result is registered.
// Each probe is one dependent RAM read: the next midpoint is known only
// once the previous key has come back, so one item is worked at a time.
// The config port (table_length, compare_signed) is always ready; write it
// only while no query is in flight.
// Reset clears the FSM, the output valid and both config registers; the
// table contents stay undefined until written.
// A stalled receiver holds the finished result in the output register; the
// block accepts the next item meanwhile and a later result waits until the
// output register frees.
module sorted_table_search
    import sts_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [LEN_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // [9:0] entry_index, [41:10] key, zero pad
    input  logic [OP_W-1:0]        i_s_tuser,  // [1:0] op
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,  // [10:0] position, zero pad
    output logic                   o_m_tuser   // [0] found
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_FIN
    } t_state;

    t_state               r_state;
    t_op                  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [LW-1:0]        r_lo;
    logic [LW-1:0]        r_hx;
    logic [LW-1:0]        r_mid;
    logic [LW-1:0]        r_pos;
    logic                 r_hit;
    logic [LEN_W-1:0]     r_tbl_len;
    logic                 r_cmp_sgn;
    logic                 r_m_valid;
    logic [POS_W-1:0]     r_m_pos;
    logic                 r_m_hit;

    t_op                  in_op;
    logic [IDX_W-1:0]     in_idx;
    logic [IN_KEY_W-1:0]  in_key;
    logic [KEY_WIDTH-1:0] in_key_ext;
    logic                 s_accept;
    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        init_mid;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_q;
    logic                 lt_kp;
    logic                 lt_pk;
    logic                 go_right;
    logic                 srch_hit;
    logic [LW-1:0]        n_lo;
    logic [LW-1:0]        n_hx;
    logic [LW-1:0]        n_mid;
    logic                 n_more;

    function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b,
                                      input logic sgn);
        logic [KEY_WIDTH-1:0] flip;
        flip = {sgn, {(KEY_WIDTH-1){1'b0}}};
        return (a ^ flip) < (b ^ flip);
    endfunction

    // Midpoint of the half-open range [lo, hx); exact find probes (lo + hx - 1) / 2.
    function automatic logic [LW-1:0] mid_of(input logic [LW-1:0] lo,
                                             input logic [LW-1:0] hx,
                                             input logic exact);
        logic [LW:0] sum;
        sum = (LW+1)'(lo) + (LW+1)'(hx) - (LW+1)'(exact);
        return sum[LW:1];
    endfunction

    assign in_op      = t_op'(i_s_tuser);
    assign in_idx     = i_s_tdata[IDX_W-1:0];
    assign in_key     = i_s_tdata[IDX_W+IN_KEY_W-1:IDX_W];
    assign in_key_ext = KEY_WIDTH'(in_key);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (32'(r_tbl_len) > 32'(DEPTH)) begin
            len_eff = LW'(DEPTH);
        end else begin
            len_eff = LW'(r_tbl_len);
        end
    end

    assign init_mid = mid_of('0, len_eff, in_op == OP_EXACT);
    assign ram_we   = s_accept && (in_op == OP_WRITE) && (32'(in_idx) < 32'(DEPTH));

    // One probe per cycle: compare the key that just came back, narrow the range.
    always_comb begin
        lt_kp    = key_less(r_key, ram_q, r_cmp_sgn);
        lt_pk    = key_less(ram_q, r_key, r_cmp_sgn);
        go_right = (r_op == OP_LOWER) ? lt_pk : !lt_kp;
        srch_hit = 1'b0;
        n_lo     = r_lo;
        n_hx     = r_hx;
        if (r_op == OP_EXACT) begin
            if (lt_kp) begin
                n_hx = r_mid;
            end else if (lt_pk) begin
                n_lo = r_mid + LW'(1);
            end else begin
                srch_hit = 1'b1;
            end
        end else if (go_right) begin
            n_lo = r_mid + LW'(1);
        end else begin
            n_hx = r_mid;
        end
        n_mid  = mid_of(n_lo, n_hx, r_op == OP_EXACT);
        n_more = !srch_hit && (n_lo < n_hx);
    end

    assign ram_raddr = (r_state == ST_SRCH) ? n_mid[AW-1:0] : init_mid[AW-1:0];

    sts_key_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_key_ext),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_tbl_len <= '0;
            r_cmp_sgn <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    CFG_TABLE_LENGTH:   r_tbl_len <= i_cfg_data;
                    CFG_COMPARE_SIGNED: r_cmp_sgn <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // in ST_FIN a taken result is always replaced by the next one
            if (r_m_valid && i_m_tready && r_state != ST_FIN) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_accept && in_op != OP_WRITE) begin
                        r_op    <= in_op;
                        r_key   <= in_key_ext;
                        r_lo    <= '0;
                        r_hx    <= len_eff;
                        r_mid   <= init_mid;
                        r_pos   <= '0;
                        r_hit   <= (in_op != OP_EXACT);
                        r_state <= (len_eff != '0) ? ST_SRCH : ST_FIN;
                    end
                end
                ST_SRCH: begin
                    r_lo  <= n_lo;
                    r_hx  <= n_hx;
                    r_mid <= n_mid;
                    if (srch_hit) begin
                        r_pos   <= r_mid;
                        r_hit   <= 1'b1;
                        r_state <= ST_FIN;
                    end else if (!n_more) begin
                        r_pos   <= (r_op == OP_EXACT) ? '0 : n_lo;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_pos   <= POS_W'(r_pos);
                        r_m_hit   <= r_hit;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_m_pos);
    assign o_m_tuser  = r_m_hit;

    // A probe is only issued while the search range is nonempty.
    a_range_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SRCH |-> r_lo < r_hx)
        else $error("search running on empty range");

    // The range never extends past the clamped table length.
    a_range_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SRCH |-> r_hx <= len_eff)
        else $error("search range beyond table length");

    // A failed exact find reports position zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss with nonzero position");

    // A write leaves the block idle: it starts no search and no result.
    a_write_no_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_op == OP_WRITE |=> r_state == ST_IDLE)
        else $error("write transaction started a search");

endmodule

FILE: bench/tb.sv
module tb;
    import sts_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_BUDGET = 1100;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } search_answer_t;

    // Tracks the key table and registers; each query is answered at acceptance time.
    class search_scoreboard;
        logic [IN_KEY_W-1:0] key_table [TABLE_DEPTH];
        logic [LEN_W-1:0]    table_len;
        bit                  signed_keys;
        search_answer_t      pending_answers [$];
        int                  errors;

        function new();
            table_len   = '0;
            signed_keys = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [LEN_W-1:0] value);
            if (addr == CFG_TABLE_LENGTH)
                table_len = value;
            else if (addr == CFG_COMPARE_SIGNED)
                signed_keys = value[0];
        endfunction

        function bit key_below(logic [IN_KEY_W-1:0] a, logic [IN_KEY_W-1:0] b);
            if (signed_keys)
                return $signed(a) < $signed(b);
            return a < b;
        endfunction

        function void note_item(t_op op, logic [IDX_W-1:0] idx, logic [IN_KEY_W-1:0] key);
            int             lo;
            int             hi;
            int             mid;
            int             span;
            bit             go_right;
            search_answer_t ans;
            span = (table_len > LEN_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(table_len);
            ans  = '0;
            if (op == OP_WRITE) begin
                key_table[idx] = key;
                return;
            end
            if (op == OP_EXACT) begin
                lo = 0;
                hi = span - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (key_below(key, key_table[mid])) begin
                        hi = mid - 1;
                    end else if (key_below(key_table[mid], key)) begin
                        lo = mid + 1;
                    end else begin
                        ans.position = POS_W'(mid);
                        ans.found    = 1'b1;
                        break;
                    end
                end
            end else begin
                lo = 0;
                hi = span;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (op == OP_LOWER)
                        go_right = key_below(key_table[mid], key);
                    else
                        go_right = !key_below(key, key_table[mid]);
                    if (go_right)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                ans.position = POS_W'(lo);
                ans.found    = 1'b1;
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic [POS_W-1:0] position, logic found);
            search_answer_t ans;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing pending: position %0d found %0b",
                         $time, position, found);
                errors++;
                return;
            end
            ans = pending_answers.pop_front();
            if (position !== ans.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, ans.position, position);
                errors++;
            end
            if (found !== ans.found) begin
                $display("%0t: found expected %0b actual %0b", $time, ans.found, found);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [LEN_W-1:0]       i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;  // [9:0] entry_index, [41:10] key, zero pad
    logic [OP_W-1:0]        i_s_tuser   = '0;  // [1:0] op
    logic                   i_m_tready  = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [10:0] position, zero pad
    logic                   o_m_tuser;         // [0] found

    search_scoreboard sb = new();
    bit               stored [TABLE_DEPTH];
    bit               no_idle = 1'b0;
    int               cycle_count = 0;
    int               sent_items = 0;

    sorted_table_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 14);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata[POS_W-1:0], o_m_tuser);
        i_m_tready <= !take_break();
    end

    // valid stays high between back-to-back items; only a gap lowers it
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx,
                             input logic [IN_KEY_W-1:0] key);
        while (take_break()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(IN_TDATA_W - IDX_W - IN_KEY_W){1'b0}}, key, idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_WRITE)
            stored[idx] = 1'b1;
        sb.note_item(op, idx, key);
        sent_items++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge i_clk);
        // a trailing write has no result to wait on
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [LEN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(addr, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < TABLE_DEPTH && stored[n])
            n++;
        return n;
    endfunction

    // ascending load from index 0; narrow spread gives runs of equal keys
    task automatic load_table(input int count, input bit signed_order);
        int unsigned         ordered [$];
        logic [IN_KEY_W-1:0] bias;
        logic [IN_KEY_W-1:0] base;
        bit                  narrow;
        bias   = signed_order ? 32'h8000_0000 : 32'h0;
        base   = $urandom();
        narrow = $urandom_range(1);
        for (int i = 0; i < count; i++)
            ordered.push_back((narrow ? base + $urandom_range(0, 3 * count) : $urandom()) ^ bias);
        ordered.sort();
        for (int i = 0; i < count; i++)
            send_item(OP_WRITE, IDX_W'(i), ordered[i] ^ bias);
    endtask

    function automatic logic [IN_KEY_W-1:0] pick_key(input int size);
        logic [IN_KEY_W-1:0] k;
        int                  r;
        r = $urandom_range(99);
        if (size == 0 || r < 20)
            return $urandom();
        k = sb.key_table[$urandom_range(0, size - 1)];
        if (r < 35)
            k = k + 1;
        else if (r < 50)
            k = k - 1;
        return k;
    endfunction

    initial begin
        int phase_no;
        int size;
        int len;
        int items;
        bit sgn;
        phase_no = 0;
        do @(posedge i_clk); while (!i_rst_n);

        // empty table straight out of reset
        send_item(OP_EXACT, '0, 32'h0);
        send_item(OP_LOWER, '1, 32'hFFFF_FFFF);
        send_item(OP_UPPER, '0, 32'h0);

        send_item(OP_WRITE, 10'd0, 32'h0000_0000);
        send_item(OP_WRITE, 10'd1, 32'h0000_0001);
        send_item(OP_WRITE, 10'd2, 32'h0000_0005);
        send_item(OP_WRITE, 10'd3, 32'h0000_0005);
        send_item(OP_WRITE, 10'd4, 32'h0000_0005);
        send_item(OP_WRITE, 10'd5, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 10'd6, 32'h8000_0000);
        send_item(OP_WRITE, 10'd7, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 10'd1023, 32'hA5A5_5A5A);
        drain();
        write_reg(CFG_TABLE_LENGTH, 11'd8);
        write_reg(CFG_COMPARE_SIGNED, 11'd0);
        send_item(OP_EXACT, '0, 32'h0000_0005);
        send_item(OP_EXACT, '0, 32'h0000_0003);  // miss
        send_item(OP_LOWER, '0, 32'h0000_0005);
        send_item(OP_UPPER, '0, 32'h0000_0005);
        send_item(OP_LOWER, '0, 32'h0000_0000);
        send_item(OP_UPPER, '0, 32'hFFFF_FFFF);  // past the end
        send_item(OP_EXACT, '0, 32'hFFFF_FFFF);
        drain();
        // same table under signed order is no longer sorted
        write_reg(CFG_COMPARE_SIGNED, 11'd1);
        send_item(OP_LOWER, '0, 32'h0000_0000);
        send_item(OP_EXACT, '0, 32'h8000_0000);
        send_item(OP_UPPER, '0, 32'hFFFF_FFFF);

        // table loads count toward the item budget
        while (sent_items < ITEM_BUDGET) begin
            if (phase_no == 1) begin
                // full table, length clamped
                size = TABLE_DEPTH;
                len  = 2047;
            end else begin
                size = $urandom_range(0, 40);
                len  = size;
            end
            sgn = $urandom_range(1);
            drain();
            write_reg(CFG_TABLE_LENGTH, LEN_W'(len));
            write_reg(CFG_COMPARE_SIGNED, LEN_W'(sgn));
            if (size > written_prefix() || $urandom_range(1))
                load_table(size, sgn);
            // queries on the full table run with no idling on either side
            if (phase_no == 1)
                no_idle = 1'b1;
            items = $urandom_range(30, 90);
            repeat (items) begin
                if ($urandom_range(99) < 15)
                    send_item(OP_WRITE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom());
                else
                    send_item(t_op'($urandom_range(1, 3)),
                              IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_key(size));
            end
            no_idle = 1'b0;
            phase_no++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
